/* rtl/signed_int_to_decimal_ascii_assert.svh */
// Assertion macros shared by the checker of signed_int_to_decimal_ascii.
// Needs nothing else; include by bare file name.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Concurrent check, quiet while reset is asserted.
`define SIDASC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check of the first cycle after a reset cycle.
`define SIDASC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (prop)) else $error(msg);

`endif

/* rtl/sidasc_pkg.sv */
// Shared types and constants of the signed integer to decimal ASCII converter.
// No dependencies.
`default_nettype none

package sidasc_pkg;

    localparam int C_VAL_W  = 32;          // input integer width
    localparam int C_NDIG   = 10;          // decimal digits of a 32-bit magnitude
    localparam int C_DIG_W  = 4;           // one BCD digit
    localparam int C_BCD_W  = C_NDIG * C_DIG_W;
    localparam int C_CNT_W  = 5;           // shift counter, 0..31
    localparam int C_IDX_W  = 4;           // digit index, 0..9
    localparam int C_CHAR_W = 8;

    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = 8'd48;
    localparam logic [C_CHAR_W-1:0] C_CHAR_MINUS = 8'd45;
    localparam logic [C_CNT_W-1:0]  C_LAST_SHIFT = C_CNT_W'(C_VAL_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;        // capture sign and magnitude, clear BCD
        logic shift;       // one double dabble step
        logic set_idx;     // point at the leading nonzero digit
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the indexed digit into the output register
    } t_cmd;

    typedef struct packed {
        logic conv_done;   // the current shift is the last one
        logic neg;         // captured value was negative
        logic out_free;    // output register can take a beat this cycle
        logic idx_zero;    // the indexed digit is the units digit
    } t_status;

endpackage

`default_nettype wire

/* rtl/sidasc_ctrl.sv */
// Sequencer of the converter: accept, shift, pick start digit, emit characters.
// Depends on sidasc_pkg.
`default_nettype none

module sidasc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  sidasc_pkg::t_status i_status,
    output sidasc_pkg::t_cmd    o_cmd
);

    sidasc_pkg::t_state r_state;
    sidasc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sidasc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            sidasc_pkg::ST_IDLE: begin
                // Hold off the sender while reset is asserted.
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = sidasc_pkg::ST_CONV;
                end
            end
            sidasc_pkg::ST_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.conv_done) begin
                    n_state = sidasc_pkg::ST_PREP;
                end
            end
            sidasc_pkg::ST_PREP: begin
                o_cmd.set_idx = 1'b1;
                n_state = i_status.neg ? sidasc_pkg::ST_SIGN : sidasc_pkg::ST_DIGIT;
            end
            sidasc_pkg::ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = sidasc_pkg::ST_DIGIT;
                end
            end
            sidasc_pkg::ST_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = sidasc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sidasc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sidasc_dp.sv */
// Datapath of the converter: magnitude, bit-serial double dabble, output register.
// Depends on sidasc_pkg.
`default_nettype none

module sidasc_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [sidasc_pkg::C_VAL_W-1:0]       i_value,
    input  sidasc_pkg::t_cmd                     i_cmd,
    output sidasc_pkg::t_status                  o_status,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [sidasc_pkg::C_CHAR_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast
);

    logic                              r_neg;
    logic [sidasc_pkg::C_VAL_W-1:0]    r_mag;
    logic [sidasc_pkg::C_BCD_W-1:0]    r_bcd;
    logic [sidasc_pkg::C_CNT_W-1:0]    r_cnt;
    logic [sidasc_pkg::C_IDX_W-1:0]    r_idx;
    logic                              r_ovalid;
    logic [sidasc_pkg::C_CHAR_W-1:0]   r_char;
    logic                              r_last;

    logic [sidasc_pkg::C_BCD_W-1:0]    n_adj;
    logic [sidasc_pkg::C_IDX_W-1:0]    n_top;
    logic [sidasc_pkg::C_DIG_W-1:0]    w_dig;

    // Add 3 to every digit of five or more ahead of the shift.
    always_comb begin
        for (int i = 0; i < sidasc_pkg::C_NDIG; i++) begin
            if (r_bcd[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W] >= 4'd5) begin
                n_adj[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W] =
                    r_bcd[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W] + 4'd3;
            end else begin
                n_adj[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W] =
                    r_bcd[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W];
            end
        end
    end

    // Highest nonzero digit; zero keeps the units digit.
    always_comb begin
        n_top = '0;
        for (int i = 0; i < sidasc_pkg::C_NDIG; i++) begin
            if (r_bcd[i*sidasc_pkg::C_DIG_W +: sidasc_pkg::C_DIG_W] != '0) begin
                n_top = sidasc_pkg::C_IDX_W'(i);
            end
        end
    end

    assign w_dig = r_bcd[{r_idx, 2'b00} +: sidasc_pkg::C_DIG_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[sidasc_pkg::C_VAL_W-1];
            r_mag <= i_value[sidasc_pkg::C_VAL_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_bcd <= {n_adj[sidasc_pkg::C_BCD_W-2:0], r_mag[sidasc_pkg::C_VAL_W-1]};
            r_mag <= {r_mag[sidasc_pkg::C_VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.set_idx) begin
            r_idx <= n_top;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Output register: load on emit, drop when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= sidasc_pkg::C_CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= sidasc_pkg::C_CHAR_ZERO + {4'b0000, w_dig};
            r_last <= (r_idx == '0);
        end
    end

    assign o_status.conv_done = (r_cnt == sidasc_pkg::C_LAST_SHIFT);
    assign o_status.neg       = r_neg;
    assign o_status.out_free  = !r_ovalid || i_m_tready;
    assign o_status.idx_zero  = (r_idx == '0);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text stream.
// Depends on sidasc_pkg, sidasc_ctrl and sidasc_dp.
//
//  Channel  | Direction | tdata                     | tlast
//  ---------+-----------+---------------------------+----------------------------
//  s (in)   | slave     | [31:0] value, signed      | -
//  m (out)  | master    | [7:0] character, ASCII    | final character of a value
//
// Sequence: one beat is taken in the idle state, then one double dabble shift per
// bit of the value and a step to locate the leading digit; characters then go out
// one per cycle while the master side takes them, 1..11 characters per value.
// The next input beat is taken right after the last character enters the
// output register, while that character may still wait on the master side.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// output register. A stall on the master side holds the sequencer in place.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,    // [31:0] value
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] character
    output logic        o_m_tlast
);

    sidasc_pkg::t_cmd    w_cmd;
    sidasc_pkg::t_status w_status;

    // Sequencer: owns the input handshake and steps the datapath.
    sidasc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: magnitude, BCD shift register and the output beat register.
    sidasc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/sidasc_chk.sv */
// Port-level checker for signed_int_to_decimal_ascii, bound to the top level.
// Depends on signed_int_to_decimal_ascii_assert.svh.
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module sidasc_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire [31:0] i_s_tdata,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [7:0]  o_m_tdata,
    input wire        o_m_tlast
);

    `SIDASC_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !o_m_tvalid, "output valid after reset")

    `SIDASC_ASSERT(a_char_set, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata == 8'd45 || (o_m_tdata >= 8'd48 && o_m_tdata <= 8'd57)), "character outside sign and digits")

    `SIDASC_ASSERT(a_sign_not_last, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata == 8'd45) |-> !o_m_tlast, "sign flagged as last")

    `SIDASC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "input taken again during conversion")

    `SIDASC_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)), "stalled output beat changed")

endmodule

bind signed_int_to_decimal_ascii sidasc_chk u_sidasc_chk (.*);

`default_nettype wire
